// ----- rtl/sep_pkg.sv -----
// Shared types and constants for the successor extract pool.
// No dependencies; used by every module of the block.
package sep_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned GROUP_N = 8;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic ext;
    logic none;
  } cell_ctl_t;

endpackage

// ----- rtl/sep_cell.sv -----
// One cell of the sorted chain: holds one pool entry and its valid bit.
// Depends on sep_pkg; exchanges data with both neighbors every cycle.
module sep_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sep_pkg::cell_ctl_t ctl,
  input  sep_pkg::data_t     key,
  input  sep_pkg::data_t     prev_val,
  input  logic               prev_valid,
  input  logic               prev_above,
  input  logic               prev_gt,
  input  sep_pkg::data_t     next_val,
  input  logic               next_valid,
  output sep_pkg::data_t     val,
  output logic               valid,
  output logic               above,
  output logic               gt,
  output sep_pkg::data_t     pick
);

  sep_pkg::data_t val_r;
  sep_pkg::data_t val_nxt;
  logic           valid_r;
  logic           valid_nxt;
  logic           key_less;

  assign key_less = val_r > key;
  assign gt       = valid_r && key_less;
  assign above    = !valid_r || key_less;
  assign val      = val_r;
  assign valid    = valid_r;
  assign pick     = (gt && !prev_gt) ? val_r : '0;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins) begin
      if (above) begin
        val_nxt   = prev_above ? prev_val : key;
        valid_nxt = valid_r || prev_valid;
      end
    end else if (ctl.ext) begin
      if (gt || ctl.none) begin
        val_nxt   = next_val;
        valid_nxt = next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- rtl/sep_group_or.sv -----
// Registered OR reduction of one group of cell pick values.
// Depends on sep_pkg; feeds the final selection in the top level.
module sep_group_or (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [sep_pkg::GROUP_N-1:0][sep_pkg::DATA_W-1:0] din,
  output logic [sep_pkg::DATA_W-1:0]             dout
);

  logic [sep_pkg::DATA_W-1:0] acc;
  logic [sep_pkg::DATA_W-1:0] dout_r;

  always_comb begin
    acc = '0;
    for (int i = 0; i < sep_pkg::GROUP_N; i++) begin
      acc = acc | din[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= acc;
    end
  end

  assign dout = dout_r;

endmodule

// ----- rtl/successor_extract_pool_unit.sv -----
// Successor extract pool: sorted chain of cells with a two-stage result path.
// Accepts one transaction per cycle while in_stall is low.
// Every cell compares and shifts in the accept cycle; the pick goes through a
// registered group OR and a final OR into the output register.
// Reset empties the pool (all cell valid bits cleared) and drops pending results.
// Depends on sep_pkg, sep_cell and sep_group_or.
module successor_extract_pool_unit #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sep_pkg::REQ_W-1:0]         in_req_type,
  input  logic signed [sep_pkg::DATA_W-1:0] in_item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sep_pkg::DATA_W-1:0] out_picked_value,
  output logic                              out_beat_key,
  output logic [sep_pkg::STAT_W-1:0]        out_status
);

  localparam int unsigned NGRP = (POOL_DEPTH + sep_pkg::GROUP_N - 1) / sep_pkg::GROUP_N;
  localparam int unsigned NPAD = NGRP * sep_pkg::GROUP_N;

  sep_pkg::data_t     cval   [POOL_DEPTH];
  logic               cvalid [POOL_DEPTH];
  logic               cabove [POOL_DEPTH];
  logic               cgt    [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] gt_vec;
  logic [NPAD-1:0][sep_pkg::DATA_W-1:0] pick_pad;
  logic [sep_pkg::DATA_W-1:0] grp_out [NGRP];

  sep_pkg::cell_ctl_t ctl;
  logic in_acc;
  logic adv_out;
  logic s1_free;
  logic any_gt;
  logic full;
  logic empty;

  logic                        s1_valid_r;
  logic                        s1_take_r;
  logic                        s1_any_r;
  sep_pkg::data_t              s1_v0_r;
  logic [sep_pkg::STAT_W-1:0]  s1_status_r;
  logic [sep_pkg::STAT_W-1:0]  s1_status_nxt;
  logic                        s1_take_nxt;

  logic                        out_valid_r;
  sep_pkg::data_t              out_picked_r;
  logic                        out_beat_r;
  logic [sep_pkg::STAT_W-1:0]  out_status_r;
  logic [sep_pkg::DATA_W-1:0]  grp_all;

  assign adv_out  = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || adv_out;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && s1_free;

  assign any_gt = |gt_vec;
  assign full   = cvalid[POOL_DEPTH-1];
  assign empty  = !cvalid[0];

  always_comb begin
    ctl.clr  = in_acc && (in_req_type == sep_pkg::REQ_CLEAR);
    ctl.ins  = in_acc && (in_req_type == sep_pkg::REQ_INSERT) && !full;
    ctl.ext  = in_acc && (in_req_type == sep_pkg::REQ_QUERY) && !empty;
    ctl.none = !any_gt;
  end

  always_comb begin
    s1_status_nxt = sep_pkg::ST_OK;
    s1_take_nxt   = 1'b0;
    case (in_req_type)
      sep_pkg::REQ_INSERT: begin
        if (full) begin
          s1_status_nxt = sep_pkg::ST_FULL;
        end
      end
      sep_pkg::REQ_QUERY: begin
        if (empty) begin
          s1_status_nxt = sep_pkg::ST_EMPTY;
        end else begin
          s1_take_nxt = 1'b1;
        end
      end
      default: begin
        s1_status_nxt = sep_pkg::ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    sep_pkg::data_t pv;
    logic           pvl;
    logic           pab;
    logic           pgt;
    sep_pkg::data_t nv;
    logic           nvl;
    sep_pkg::data_t pk;

    if (i == 0) begin : g_first
      assign pv  = '0;
      assign pvl = 1'b1;
      assign pab = 1'b0;
      assign pgt = 1'b0;
    end else begin : g_mid
      assign pv  = cval[i-1];
      assign pvl = cvalid[i-1];
      assign pab = cabove[i-1];
      assign pgt = cgt[i-1];
    end

    if (i == POOL_DEPTH - 1) begin : g_last
      assign nv  = '0;
      assign nvl = 1'b0;
    end else begin : g_inner
      assign nv  = cval[i+1];
      assign nvl = cvalid[i+1];
    end

    sep_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key        (in_item_value),
      .prev_val   (pv),
      .prev_valid (pvl),
      .prev_above (pab),
      .prev_gt    (pgt),
      .next_val   (nv),
      .next_valid (nvl),
      .val        (cval[i]),
      .valid      (cvalid[i]),
      .above      (cabove[i]),
      .gt         (cgt[i]),
      .pick       (pk)
    );

    assign gt_vec[i]   = cgt[i];
    assign pick_pad[i] = pk;
  end

  for (genvar j = POOL_DEPTH; j < NPAD; j++) begin : g_pad
    assign pick_pad[j] = '0;
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    sep_group_or u_grp (
      .clk  (clk),
      .en   (in_acc),
      .din  (pick_pad[g*sep_pkg::GROUP_N +: sep_pkg::GROUP_N]),
      .dout (grp_out[g])
    );
  end

  always_comb begin
    grp_all = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_all = grp_all | grp_out[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv_out) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_take_r   <= s1_take_nxt;
      s1_any_r    <= any_gt;
      s1_v0_r     <= cval[0];
      s1_status_r <= s1_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_beat_r   <= s1_take_r && s1_any_r;
      if (!s1_take_r) begin
        out_picked_r <= '0;
      end else if (s1_any_r) begin
        out_picked_r <= grp_all;
      end else begin
        out_picked_r <= s1_v0_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_picked_value = out_picked_r;
  assign out_beat_key     = out_beat_r;
  assign out_status       = out_status_r;

endmodule

// ----- tb/tb_successor_extract_pool_unit.sv -----
// Self-checking testbench for successor_extract_pool_unit: a shadow sorted pool predicts
// every result of clear, insert, query-extract and unused-type transactions under random idling and output stalls.
// Depends on sep_pkg and the successor_extract_pool_unit RTL.
module tb_successor_extract_pool_unit;

  localparam int unsigned POOL_DEPTH = 64;
  localparam logic [sep_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam sep_pkg::data_t VAL_MIN = 32'sh8000_0000;
  localparam sep_pkg::data_t VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    sep_pkg::data_t             picked;
    logic                       beat;
    logic [sep_pkg::STAT_W-1:0] status;
  } pick_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [sep_pkg::REQ_W-1:0]  in_req_type;
  sep_pkg::data_t             in_item_value;
  logic                       out_valid;
  logic                       out_stall;
  sep_pkg::data_t             out_picked_value;
  logic                       out_beat_key;
  logic [sep_pkg::STAT_W-1:0] out_status;

  sep_pkg::data_t shadow_pool[$];
  pick_result_t   pending_picks[$];
  int             mismatches = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;

  successor_extract_pool_unit #(
    .POOL_DEPTH(POOL_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_picked_value(out_picked_value),
    .out_beat_key    (out_beat_key),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_successor_extract_pool_unit: errors");
    $finish;
  end

  function automatic pick_result_t predict_pool_result(logic [sep_pkg::REQ_W-1:0] req,
                                                       sep_pkg::data_t val);
    pick_result_t res;
    int           pos;
    res = '0;
    pos = 0;
    case (req)
      sep_pkg::REQ_CLEAR: shadow_pool.delete();
      sep_pkg::REQ_INSERT: begin
        if (shadow_pool.size() >= POOL_DEPTH) begin
          res.status = sep_pkg::ST_FULL;
        end else begin
          while (pos < shadow_pool.size() && shadow_pool[pos] <= val) pos++;
          shadow_pool.insert(pos, val);
        end
      end
      sep_pkg::REQ_QUERY: begin
        if (shadow_pool.size() == 0) begin
          res.status = sep_pkg::ST_EMPTY;
        end else begin
          while (pos < shadow_pool.size() && shadow_pool[pos] <= val) pos++;
          if (pos == shadow_pool.size()) begin
            pos = 0;
          end else begin
            res.beat = 1'b1;
          end
          res.picked = shadow_pool[pos];
          shadow_pool.delete(pos);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic sep_pkg::data_t rand_value();
    case ($urandom_range(0, 4))
      0: return sep_pkg::data_t'(int'($urandom_range(0, 16)) - 8);
      1: return VAL_MIN + sep_pkg::data_t'($urandom_range(0, 3));
      2: return VAL_MAX - sep_pkg::data_t'($urandom_range(0, 3));
      default: return sep_pkg::data_t'($urandom);
    endcase
  endfunction

  function automatic sep_pkg::data_t rand_key();
    if (shadow_pool.size() != 0 && $urandom_range(0, 2) == 0)
      return shadow_pool[$urandom_range(0, shadow_pool.size() - 1)];
    return rand_value();
  endfunction

  // Call just after a falling edge; returns just after a falling edge.
  task automatic send_request(input logic [sep_pkg::REQ_W-1:0] req,
                              input sep_pkg::data_t val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_req_type   = req;
    in_item_value = val;
    do @(posedge clk); while (in_stall);
    pending_picks.push_back(predict_pool_result(req, val));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pick_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: picked=%0d beat=%0b status=%0d",
                   out_picked_value, out_beat_key, out_status);
      end else begin
        exp_res = pending_picks.pop_front();
        if (out_picked_value !== exp_res.picked || out_beat_key !== exp_res.beat ||
            out_status !== exp_res.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected picked=%0d beat=%0b status=%0d, ",
                      "got picked=%0d beat=%0b status=%0d"},
                     exp_res.picked, exp_res.beat, exp_res.status,
                     out_picked_value, out_beat_key, out_status);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(sep_pkg::REQ_QUERY, 0);
    send_request(sep_pkg::REQ_CLEAR, 0);
    send_request(sep_pkg::REQ_INSERT, VAL_MIN);
    send_request(sep_pkg::REQ_INSERT, VAL_MAX);
    send_request(sep_pkg::REQ_INSERT, 0);
    send_request(sep_pkg::REQ_INSERT, 0);
    send_request(sep_pkg::REQ_INSERT, -1);
    send_request(REQ_UNUSED, VAL_MAX);
    send_request(sep_pkg::REQ_QUERY, VAL_MAX);
    send_request(sep_pkg::REQ_QUERY, VAL_MIN);
    send_request(sep_pkg::REQ_QUERY, 0);
    send_request(sep_pkg::REQ_QUERY, -1);
    send_request(sep_pkg::REQ_INSERT, 32'sh5555_5555);
    send_request(sep_pkg::REQ_INSERT, 32'shaaaa_aaaa);
    send_request(sep_pkg::REQ_QUERY, 0);
    send_request(sep_pkg::REQ_CLEAR, VAL_MAX);
    send_request(sep_pkg::REQ_QUERY, VAL_MIN);
    send_request(sep_pkg::REQ_INSERT, 5);
    send_request(sep_pkg::REQ_QUERY, 5);
    send_request(sep_pkg::REQ_QUERY, 5);
  endtask

  task automatic test_fill_to_capacity();
    while (shadow_pool.size() < POOL_DEPTH) send_request(sep_pkg::REQ_INSERT, rand_value());
    repeat (3) send_request(sep_pkg::REQ_INSERT, rand_value());
    repeat (8) send_request(sep_pkg::REQ_QUERY, rand_key());
  endtask

  task automatic test_random_mix(input int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        send_request(sep_pkg::REQ_CLEAR, rand_value());
      end else if (sel < 5) begin
        send_request(REQ_UNUSED, rand_value());
      end else if (sel < 53) begin
        send_request(sep_pkg::REQ_INSERT, rand_value());
      end else begin
        send_request(sep_pkg::REQ_QUERY, rand_key());
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = sep_pkg::REQ_CLEAR;
    in_item_value = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct  = 12;
    recv_stall_pct = 52;
    test_directed();
    test_random_mix(100);
    test_fill_to_capacity();

    send_idle_pct  = 52;
    recv_stall_pct = 12;
    test_random_mix(100);
    test_fill_to_capacity();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_mix(100);
    test_fill_to_capacity();
    in_valid = 1'b0;

    while (pending_picks.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("tb_successor_extract_pool_unit: clean");
    end else begin
      $display("tb_successor_extract_pool_unit: errors");
    end
    $finish;
  end

endmodule
